/* rtl/core/ttycon_pkg.sv */
// Shared types and constants of the console core: codes, FSM states, and the
// control/status structs between controller and datapath. No dependencies.
package ttycon_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    localparam logic [11:0] OFF_PUTC    = 12'h000;
    localparam logic [11:0] OFF_COUNT   = 12'h004;
    localparam logic [11:0] OFF_CMD     = 12'h008;
    localparam logic [11:0] OFF_ADDR_LO = 12'h010;
    localparam logic [11:0] OFF_LEN     = 12'h014;
    localparam logic [11:0] OFF_ADDR_HI = 12'h018;

    localparam logic [31:0] CMD_IRQ_OFF = 32'd0;
    localparam logic [31:0] CMD_IRQ_ON  = 32'd1;
    localparam logic [31:0] CMD_TX      = 32'd2;
    localparam logic [31:0] CMD_RX      = 32'd3;

    localparam logic [2:0] KIND_ACK   = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_TXB   = 3'd2;
    localparam logic [2:0] KIND_MEMW  = 3'd3;
    localparam logic [2:0] KIND_FETCH = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BAD_OFF = 3'd1;
    localparam logic [2:0] ERR_BAD_CMD = 3'd2;
    localparam logic [2:0] ERR_RX_LONG = 3'd3;
    localparam logic [2:0] ERR_CLAMP   = 3'd4;
    localparam logic [2:0] ERR_DROP    = 3'd5;

    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_TX,
        OP_RX
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SINGLE,
        S_TX,
        S_RX_RD,
        S_RX_CAP,
        S_RX_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit_single;
        logic tx_step;
        logic rx_issue;
        logic rx_cap;
        logic rx_emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
        logic tx_last;
        logic cap_last;
        logic rx_last;
    } sts_t;

endpackage

/* rtl/core/ttycon_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttycon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ttycon_ctrl.sv */
// Controller FSM of the console core: sequences accept, execute and result
// emission. Depends on ttycon_pkg.
module ttycon_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ttycon_pkg::sts_t  sts,
    output ttycon_pkg::cmd_t  cmd
);
    import ttycon_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_TX:   state_next = S_TX;
                    OP_RX:   state_next = S_RX_RD;
                    default: state_next = S_SINGLE;
                endcase
            end
            S_SINGLE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TX:
            begin
                if (sts.out_free && sts.tx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RX_RD:
            begin
                state_next = S_RX_CAP;
            end
            S_RX_CAP:
            begin
                state_next = sts.cap_last ? S_RX_EMIT : S_RX_RD;
            end
            S_RX_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rx_last ? S_IDLE : S_RX_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_EXEC:    cmd.exec = 1'b1;
            S_SINGLE:  cmd.emit_single = sts.out_free;
            S_TX:      cmd.tx_step = sts.out_free;
            S_RX_RD:   cmd.rx_issue = 1'b1;
            S_RX_CAP:  cmd.rx_cap = 1'b1;
            S_RX_EMIT: cmd.rx_emit = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

/* rtl/core/ttycon_dp.sv */
// Datapath of the console core: register state, receive buffer, DMA walk
// counters and the output register. Depends on ttycon_pkg, ttycon_ram.
module ttycon_dp #(
    parameter int RX_DEPTH    = 128,
    parameter int CHUNK_BYTES = 64,
    parameter int MAX_TX_LEN  = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ttycon_pkg::cmd_t  cmd,
    output ttycon_pkg::sts_t  sts,
    input  logic [55:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [159:0]      m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import ttycon_pkg::*;

    localparam int AW   = $clog2(RX_DEPTH);
    localparam int CW   = $clog2(RX_DEPTH + 1);
    localparam int PW   = CW + 1;
    localparam int LMAX = (MAX_TX_LEN > RX_DEPTH) ? MAX_TX_LEN : RX_DEPTH;
    localparam int RW   = $clog2(LMAX + 1);

    // item
    logic [1:0]  mode_reg;
    logic [11:0] off_reg;
    logic [31:0] val_reg;
    logic [7:0]  byte_reg;

    // architectural state
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic          irq_en_reg, irq_en_next;
    logic [63:0]   addr_reg, addr_next;
    logic [31:0]   len_reg, len_next;

    // per-item work
    logic [2:0]    err_reg, irq_dummy_unused;
    logic          irq_item_reg;
    logic [2:0]    skind_reg;
    logic [7:0]    srdata_reg, stxb_reg;
    logic [63:0]   waddr_reg;
    logic [RW-1:0] remain_reg;
    logic [AW-1:0] rptr_reg;
    logic [63:0]   word_reg;
    logic [3:0]    wcnt_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_kind_reg, m_err_reg;
    logic [7:0]  m_rdata_reg, m_txb_reg;
    logic [63:0] m_addr_reg, m_data_reg;
    logic [6:0]  m_cnt_reg;
    logic        m_irq_reg, m_last_reg;

    // decode
    op_t           d_op;
    logic [2:0]    d_kind, d_err;
    logic [7:0]    d_rdata, d_txb;
    logic          ram_we;
    logic [PW-1:0] wr_sum, hd_sum;
    logic [AW-1:0] wr_ptr, hd_wrap;
    logic [RW-1:0] tx_len;
    logic [31:0]   tx_n;
    logic [3:0]    rx_n;
    logic [7:0]    ram_rdata;
    logic          load_out;

    assign irq_dummy_unused = 3'd0;

    assign wr_sum  = PW'(head_reg) + PW'(count_reg);
    assign wr_ptr  = (wr_sum >= PW'(RX_DEPTH)) ? AW'(wr_sum - PW'(RX_DEPTH)) : AW'(wr_sum);
    assign hd_sum  = PW'(head_reg) + PW'(len_reg[CW-1:0]);
    assign hd_wrap = (hd_sum >= PW'(RX_DEPTH)) ? AW'(hd_sum - PW'(RX_DEPTH)) : AW'(hd_sum);
    assign tx_len  = (len_reg > 32'(MAX_TX_LEN)) ? RW'(MAX_TX_LEN) : len_reg[RW-1:0];
    assign tx_n    = (32'(remain_reg) > 32'(CHUNK_BYTES)) ? 32'(CHUNK_BYTES) : 32'(remain_reg);
    assign rx_n    = (remain_reg > RW'(8)) ? 4'd8 : remain_reg[3:0];

    always_comb
    begin
        d_op        = OP_SINGLE;
        d_kind      = KIND_ACK;
        d_err       = ERR_NONE;
        d_rdata     = 8'd0;
        d_txb       = 8'd0;
        ram_we      = 1'b0;
        count_next  = count_reg;
        head_next   = head_reg;
        irq_en_next = irq_en_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        case (mode_reg)
            MODE_WRITE:
            begin
                case (off_reg)
                    OFF_PUTC:
                    begin
                        d_kind = KIND_TXB;
                        d_txb  = val_reg[7:0];
                    end
                    OFF_CMD:
                    begin
                        case (val_reg)
                            CMD_IRQ_OFF: irq_en_next = 1'b0;
                            CMD_IRQ_ON:  irq_en_next = 1'b1;
                            CMD_TX:
                            begin
                                if (len_reg != 32'd0)
                                begin
                                    d_op = OP_TX;
                                end
                                if (len_reg > 32'(MAX_TX_LEN))
                                begin
                                    d_err = ERR_CLAMP;
                                end
                            end
                            CMD_RX:
                            begin
                                if (len_reg > 32'(count_reg))
                                begin
                                    d_err = ERR_RX_LONG;
                                end
                                else if (len_reg != 32'd0)
                                begin
                                    d_op       = OP_RX;
                                    head_next  = hd_wrap;
                                    count_next = count_reg - len_reg[CW-1:0];
                                end
                            end
                            default: d_err = ERR_BAD_CMD;
                        endcase
                    end
                    OFF_ADDR_LO: addr_next = {addr_reg[63:32], val_reg};
                    OFF_ADDR_HI: addr_next = {val_reg, addr_reg[31:0]};
                    OFF_LEN:     len_next  = val_reg;
                    default:     d_err     = ERR_BAD_OFF;
                endcase
            end
            MODE_READ:
            begin
                d_kind = KIND_READ;
                if (off_reg == OFF_COUNT)
                begin
                    d_rdata = 8'(count_reg);
                end
                else
                begin
                    d_err = ERR_BAD_OFF;
                end
            end
            MODE_RX:
            begin
                if (count_reg < CW'(RX_DEPTH))
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    d_err = ERR_DROP;
                end
            end
            default:
            begin
                d_kind = KIND_ACK;
            end
        endcase
    end

    ttycon_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (cmd.exec && ram_we),
        .waddr (wr_ptr),
        .wdata (byte_reg),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tuser;
            off_reg  <= s_tdata[11:0];
            val_reg  <= s_tdata[43:12];
            byte_reg <= s_tdata[51:44];
        end
        if (cmd.exec)
        begin
            err_reg      <= d_err | irq_dummy_unused;
            irq_item_reg <= irq_en_next && (count_next != '0);
            skind_reg    <= d_kind;
            srdata_reg   <= d_rdata;
            stxb_reg     <= d_txb;
            waddr_reg    <= addr_reg;
            remain_reg   <= (d_op == OP_TX) ? tx_len : len_reg[RW-1:0];
            rptr_reg     <= head_reg;
            word_reg     <= 64'd0;
            wcnt_reg     <= 4'd0;
        end
        if (cmd.tx_step)
        begin
            waddr_reg  <= waddr_reg + 64'(tx_n);
            remain_reg <= remain_reg - tx_n[RW-1:0];
        end
        if (cmd.rx_issue)
        begin
            rptr_reg <= (rptr_reg == AW'(RX_DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (cmd.rx_cap)
        begin
            word_reg <= word_reg | (64'(ram_rdata) << {wcnt_reg[2:0], 3'b000});
            wcnt_reg <= wcnt_reg + 4'd1;
        end
        if (cmd.rx_emit)
        begin
            waddr_reg  <= waddr_reg + 64'(rx_n);
            remain_reg <= remain_reg - RW'(rx_n);
            word_reg   <= 64'd0;
            wcnt_reg   <= 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            head_reg    <= '0;
            irq_en_reg  <= 1'b0;
            addr_reg    <= 64'd0;
            len_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg  <= count_next;
                head_reg   <= head_next;
                irq_en_reg <= irq_en_next;
                addr_reg   <= addr_next;
                len_reg    <= len_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign load_out     = cmd.emit_single || cmd.tx_step || cmd.rx_emit;
    assign m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_irq_reg <= irq_item_reg;
            m_err_reg <= err_reg;
        end
        if (cmd.emit_single)
        begin
            m_kind_reg  <= skind_reg;
            m_rdata_reg <= srdata_reg;
            m_txb_reg   <= stxb_reg;
            m_addr_reg  <= 64'd0;
            m_data_reg  <= 64'd0;
            m_cnt_reg   <= 7'd0;
            m_last_reg  <= 1'b1;
        end
        if (cmd.tx_step)
        begin
            m_kind_reg  <= KIND_FETCH;
            m_rdata_reg <= 8'd0;
            m_txb_reg   <= 8'd0;
            m_addr_reg  <= waddr_reg;
            m_data_reg  <= 64'd0;
            m_cnt_reg   <= tx_n[6:0];
            m_last_reg  <= sts.tx_last;
        end
        if (cmd.rx_emit)
        begin
            m_kind_reg  <= KIND_MEMW;
            m_rdata_reg <= 8'd0;
            m_txb_reg   <= 8'd0;
            m_addr_reg  <= waddr_reg;
            m_data_reg  <= word_reg;
            m_cnt_reg   <= 7'(rx_n);
            m_last_reg  <= sts.rx_last;
        end
    end

    assign sts.op       = d_op;
    assign sts.out_free = !m_valid_reg || m_tready;
    assign sts.tx_last  = 32'(remain_reg) <= 32'(CHUNK_BYTES);
    assign sts.cap_last = (wcnt_reg + 4'd1) == rx_n;
    assign sts.rx_last  = remain_reg <= RW'(8);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_err_reg, m_irq_reg, m_cnt_reg, m_data_reg, m_addr_reg,
                       m_txb_reg, m_rdata_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RX_DEPTH))
        else $error("rx count above buffer depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending transfer");

    a_tx_remain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tx_step |-> remain_reg != '0)
        else $error("fetch chunk with nothing left");

    a_word_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rx_emit |-> (wcnt_reg == rx_n && rx_n != 4'd0))
        else $error("write word emitted before all bytes read");

endmodule

/* rtl/core/tty_console_with_rx_buffer_and_dma_core.sv */
// Top level of the console core with receive buffer and DMA walk.
// Depends on ttycon_pkg, ttycon_ctrl, ttycon_dp (which holds ttycon_ram).
//
// One item at a time. A register access or line byte passes accept, execute
// and emit, emit waiting for a free output register. A transmit command
// emits one fetch chunk per cycle while the output register is free. A
// receive command reads the buffer byte by byte through the RAM's registered
// read (an issue and a capture state per byte) and emits write words of up to
// 8 bytes. The output register lets the next item be accepted while the last
// result waits. The buffer RAM needs no clearing pass after reset.
module tty_console_with_rx_buffer_and_dma_core #(
    parameter int RX_DEPTH    = 128,
    parameter int CHUNK_BYTES = 64,
    parameter int MAX_TX_LEN  = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // register_offset[11:0], write_value[43:12], rx_byte[51:44]
    input  logic [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // read_data[7:0], tx_byte[15:8], mem_address[79:16],
                                    // mem_data[143:80], byte_count[150:144], irq[151],
                                    // error_code[154:152]
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast    // last
);
    import ttycon_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ttycon_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttycon_dp #(
        .RX_DEPTH    (RX_DEPTH),
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_TX_LEN  (MAX_TX_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
